// ----- rtl/i2c_trf_pkg.sv -----
// Package with the item types, codes and controller types of the I2C target register file.
`timescale 1ns / 1ps

package i2c_trf_pkg;

    // Default number of registers in the bank.
    localparam int REG_COUNT_DEFAULT = 16;

    // Bus event codes carried by an input item.
    typedef enum logic [1:0] {
        REQ_ADDR  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_STOP  = 2'd3
    } req_e_t;

    // Response codes carried by a result item.
    localparam logic [1:0] RESP_ACK  = 2'd0;
    localparam logic [1:0] RESP_NACK = 2'd1;
    localparam logic [1:0] RESP_DONE = 2'd2;

    // One input item.
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] write_byte;
        logic       clear_changed;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] read_byte;
        logic [1:0] response;
        logic       busy_res;
        logic       changed;
        logic [7:0] pointer_now;
    } out_item_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic op_addr;
        logic op_ptr;
        logic op_data;
        logic op_read;
        logic op_stop;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req_type;
        logic       expect_ptr;
    } status_t;

endpackage

// ----- rtl/i2c_trf_ctrl.sv -----
// Controller state machine of the I2C target register file.
`timescale 1ns / 1ps

module i2c_trf_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  i2c_trf_pkg::status_t status,
    output i2c_trf_pkg::cmd_t    cmd,
    output logic                busy
);

    i2c_trf_pkg::state_t state_reg;
    i2c_trf_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2c_trf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        case (state_reg)
            i2c_trf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = i2c_trf_pkg::ST_EXEC;
                end
            end
            i2c_trf_pkg::ST_EXEC:
            begin
                busy     = 1'b1;
                cmd.emit = 1'b1;
                case (i2c_trf_pkg::req_e_t'(status.req_type))
                    i2c_trf_pkg::REQ_ADDR:  cmd.op_addr = 1'b1;
                    i2c_trf_pkg::REQ_WRITE:
                    begin
                        if (status.expect_ptr)
                        begin
                            cmd.op_ptr = 1'b1;
                        end
                        else
                        begin
                            cmd.op_data = 1'b1;
                        end
                    end
                    i2c_trf_pkg::REQ_READ:  cmd.op_read = 1'b1;
                    default:                cmd.op_stop = 1'b1;
                endcase
                state_next = i2c_trf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = i2c_trf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/i2c_trf_datapath.sv -----
// Datapath of the I2C target register file: register bank, pointer and flags.
`timescale 1ns / 1ps

module i2c_trf_datapath
#(
    parameter int REG_COUNT = i2c_trf_pkg::REG_COUNT_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  i2c_trf_pkg::in_item_t  req,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  i2c_trf_pkg::cmd_t      cmd,
    output i2c_trf_pkg::status_t   status,
    output i2c_trf_pkg::out_item_t result,
    output logic                   done
);

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [8:0] COUNT9 = 9'(REG_COUNT);

    // Bank storage; entries that were never written read as zero.
    logic [7:0]           mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;

    i2c_trf_pkg::in_item_t  item_reg;
    i2c_trf_pkg::out_item_t result_reg;
    i2c_trf_pkg::out_item_t result_next;
    logic [7:0]             ptr_reg;
    logic [7:0]             ptr_next;
    logic                   expect_reg;
    logic                   expect_next;
    logic                   busy_flag_reg;
    logic                   busy_flag_next;
    logic                   changed_reg;
    logic                   changed_next;
    logic                   mode_reg;
    logic                   done_reg;
    logic [7:0]             rd_data_reg;
    logic                   rd_valid_reg;
    logic [IDX_W-1:0]       idx;
    logic [8:0]             ptr_inc;
    logic [7:0]             ptr_adv;
    logic [7:0]             ptr_load;

    // Bank index from the pointer, falling back to register zero when out of range.
    assign idx = ({1'b0, ptr_reg} < COUNT9) ? ptr_reg[IDX_W-1:0] : '0;

    // Pointer advance with wrap, and pointer byte load with range check.
    assign ptr_inc  = {1'b0, ptr_reg} + 9'd1;
    assign ptr_adv  = (ptr_inc >= COUNT9) ? 8'd0 : ptr_inc[7:0];
    assign ptr_load = ({1'b0, item_reg.write_byte} < COUNT9) ? item_reg.write_byte : 8'd0;

    assign status.req_type   = item_reg.req_type;
    assign status.expect_ptr = expect_reg;
    assign result            = result_reg;
    assign done              = done_reg;

    // Item execution: next pointer, flags and result.
    always_comb
    begin
        ptr_next       = ptr_reg;
        expect_next    = expect_reg;
        busy_flag_next = busy_flag_reg;
        changed_next   = changed_reg;
        result_next    = result_reg;
        if (cmd.emit)
        begin
            if (item_reg.clear_changed)
            begin
                changed_next = 1'b0;
            end
            result_next.read_byte = 8'd0;
            result_next.response  = i2c_trf_pkg::RESP_ACK;
            if (cmd.op_addr)
            begin
                ptr_next       = 8'd0;
                busy_flag_next = 1'b1;
                expect_next    = mode_reg;
            end
            if (cmd.op_ptr)
            begin
                ptr_next    = ptr_load;
                expect_next = 1'b0;
            end
            if (cmd.op_data)
            begin
                changed_next = 1'b1;
                ptr_next     = ptr_adv;
            end
            if (cmd.op_read)
            begin
                result_next.read_byte = rd_valid_reg ? rd_data_reg : 8'd0;
                result_next.response  = i2c_trf_pkg::RESP_NACK;
                ptr_next              = ptr_adv;
            end
            if (cmd.op_stop)
            begin
                busy_flag_next       = 1'b0;
                result_next.response = i2c_trf_pkg::RESP_DONE;
            end
            result_next.busy_res    = busy_flag_next;
            result_next.changed     = changed_next;
            result_next.pointer_now = ptr_next;
        end
    end

    // Control state and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= 8'd0;
            expect_reg    <= 1'b0;
            busy_flag_reg <= 1'b0;
            changed_reg   <= 1'b0;
            mode_reg      <= 1'b0;
            done_reg      <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            expect_reg    <= expect_next;
            busy_flag_reg <= busy_flag_next;
            changed_reg   <= changed_next;
            done_reg      <= cmd.emit;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (cmd.op_data)
            begin
                valid_reg[idx] <= 1'b1;
            end
        end
    end

    // Payload registers: captured item and result.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
        result_reg <= result_next;
    end

    // Bank write port and registered read port at the pointer.
    always_ff @(posedge clk)
    begin
        if (cmd.op_data)
        begin
            mem[idx] <= item_reg.write_byte;
        end
        rd_data_reg <= mem[idx];
    end

    // Valid bit of the entry being read, registered alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[idx];
        end
    end

endmodule

// ----- rtl/i2c_target_register_file.sv -----
// Top level of the I2C target register file.
`timescale 1ns / 1ps

//  Channel   Ports                        Handshake
//  input     req (in_item_t)              taken when start is high and busy is low
//  result    result (out_item_t)          valid for one cycle while done is high
//  config    cfg_we, cfg_wdata            written when cfg_we is high
//
//  Each item is executed in the controller's execute state, and its result
//  appears with done in the cycle after. The bank read port is registered,
//  so the read is issued in the cycle the item is taken.
//  Reset clears the pointer, the flags, the mode register and the bank valid bits.
//  The receiver cannot stall: a result is shown for exactly one cycle.

module i2c_target_register_file
#(
    parameter int REG_COUNT = i2c_trf_pkg::REG_COUNT_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  i2c_trf_pkg::in_item_t  req,
    output i2c_trf_pkg::out_item_t result,
    output logic                   done,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata
);

    i2c_trf_pkg::cmd_t    cmd;
    i2c_trf_pkg::status_t status;

    // Controller.
    i2c_trf_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Datapath.
    i2c_trf_datapath
    #(
        .REG_COUNT (REG_COUNT)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .done      (done)
    );

endmodule

// ----- tb/i2c_target_register_file_tb.sv -----
// Self-checking testbench for the I2C target register file: directed and random bus events.
`timescale 1ns / 1ps

module i2c_target_register_file_tb;

    localparam int NREG = i2c_trf_pkg::REG_COUNT_DEFAULT;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS = 80;
    localparam int MAX_PRINTED = 20;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    i2c_trf_pkg::in_item_t  req;
    i2c_trf_pkg::out_item_t result;
    logic                   done;
    logic                   cfg_we;
    logic                   cfg_wdata;

    // Shadow copy of the register file, updated as each item is accepted.
    logic [7:0] bank_model [NREG];
    logic [7:0] ptr_model;
    logic       arm_ptr_model;
    logic       busy_model;
    logic       changed_model;
    logic       mode_model;

    // Results predicted for accepted items, oldest first.
    i2c_trf_pkg::out_item_t expected_results [$];

    int errors;
    int items_sent;
    int results_checked;
    int addr_count;
    int data_write_count;
    int ptr_write_count;
    int read_count;
    int stop_count;
    int mode_writes;
    bit idle_enable;

    i2c_target_register_file dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .result    (result),
        .done      (done),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Free-running clock with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Safety net in case the block stops answering.
    initial
    begin
        #2ms;
        $display("Timeout: %0d items sent, %0d results checked, %0d still expected",
                 items_sent, results_checked, expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < MAX_PRINTED)
        begin
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        errors++;
    endtask

    // Advance the pointer by one data byte, wrapping at the end of the bank.
    function automatic logic [7:0] next_pointer(input logic [7:0] p);
        int unsigned n;
        n = int'(p) + 1;
        if (n >= NREG)
        begin
            n = 0;
        end
        return n[7:0];
    endfunction

    // Work out the result of one bus event and update the shadow state.
    function automatic i2c_trf_pkg::out_item_t predict_bus_event(input i2c_trf_pkg::in_item_t it);
        i2c_trf_pkg::out_item_t r;
        int unsigned            idx;
        r = '0;
        idx = (int'(ptr_model) < NREG) ? int'(ptr_model) : 0;
        if (it.clear_changed)
        begin
            changed_model = 1'b0;
        end
        case (i2c_trf_pkg::req_e_t'(it.req_type))
            i2c_trf_pkg::REQ_ADDR:
            begin
                ptr_model = 8'd0;
                busy_model = 1'b1;
                arm_ptr_model = mode_model;
                r.response = i2c_trf_pkg::RESP_ACK;
                addr_count++;
            end
            i2c_trf_pkg::REQ_WRITE:
            begin
                if (arm_ptr_model)
                begin
                    // A pointer byte past the bank selects register 0.
                    ptr_model = (int'(it.write_byte) < NREG) ? it.write_byte : 8'd0;
                    arm_ptr_model = 1'b0;
                    ptr_write_count++;
                end
                else
                begin
                    bank_model[idx] = it.write_byte;
                    changed_model = 1'b1;
                    ptr_model = next_pointer(ptr_model);
                    data_write_count++;
                end
                r.response = i2c_trf_pkg::RESP_ACK;
            end
            i2c_trf_pkg::REQ_READ:
            begin
                r.read_byte = bank_model[idx];
                ptr_model = next_pointer(ptr_model);
                r.response = i2c_trf_pkg::RESP_NACK;
                read_count++;
            end
            default:
            begin
                busy_model = 1'b0;
                r.response = i2c_trf_pkg::RESP_DONE;
                stop_count++;
            end
        endcase
        r.busy_res = busy_model;
        r.changed = changed_model;
        r.pointer_now = ptr_model;
        return r;
    endfunction

    function automatic i2c_trf_pkg::in_item_t make_item(input i2c_trf_pkg::req_e_t kind,
                                                        input logic [7:0] b,
                                                        input logic clr);
        i2c_trf_pkg::in_item_t it;
        it.req_type = kind;
        it.write_byte = b;
        it.clear_changed = clr;
        return it;
    endfunction

    // Offer one item, wait until it is taken, record its expected result and maybe idle.
    // Called and returns at a rising edge.
    task automatic send_item(input i2c_trf_pkg::in_item_t it);
        bit taken;
        start <= 1'b1;
        req <= it;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        expected_results.push_back(predict_bus_event(it));
        items_sent++;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Write the mode register once the block has gone quiet.
    task automatic write_select_mode(input logic v);
        start <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_model = v;
        mode_writes++;
    endtask

    // Compare every result with the oldest prediction.
    always @(negedge clk)
    begin
        i2c_trf_pkg::out_item_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing expected", 1, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.read_byte !== want.read_byte)
                begin
                    report_mismatch("read_byte", result.read_byte, want.read_byte);
                end
                if (result.response !== want.response)
                begin
                    report_mismatch("response", result.response, want.response);
                end
                if (result.busy_res !== want.busy_res)
                begin
                    report_mismatch("busy_res", result.busy_res, want.busy_res);
                end
                if (result.changed !== want.changed)
                begin
                    report_mismatch("changed", result.changed, want.changed);
                end
                if (result.pointer_now !== want.pointer_now)
                begin
                    report_mismatch("pointer_now", result.pointer_now, want.pointer_now);
                end
                results_checked++;
            end
        end
    end

    // Events straight after reset: a read and a write with no transaction open, and a lone stop.
    task automatic test_reset_state();
        send_item(make_item(i2c_trf_pkg::REQ_READ, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_WRITE, 8'h00, 1'b1));
        send_item(make_item(i2c_trf_pkg::REQ_STOP, 8'hFF, 1'b0));
    endtask

    // Plain data mode: every written byte is data, reads follow the pointer.
    task automatic test_plain_transfers();
        write_select_mode(1'b0);
        send_item(make_item(i2c_trf_pkg::REQ_ADDR, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_WRITE, 8'hFF, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_WRITE, 8'h5A, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_STOP, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_ADDR, 8'hFF, 1'b1));
        send_item(make_item(i2c_trf_pkg::REQ_READ, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_READ, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_READ, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_STOP, 8'h00, 1'b0));
    endtask

    // Register-select mode: last register with wrap, out-of-range pointers, clear with write.
    task automatic test_pointer_select();
        write_select_mode(1'b1);
        send_item(make_item(i2c_trf_pkg::REQ_ADDR, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_WRITE, 8'(NREG - 1), 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_WRITE, 8'hA5, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_STOP, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_ADDR, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_WRITE, 8'(NREG), 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_READ, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_STOP, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_ADDR, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_WRITE, 8'hFF, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_WRITE, 8'h3C, 1'b1));
        send_item(make_item(i2c_trf_pkg::REQ_READ, 8'h00, 1'b1));
        send_item(make_item(i2c_trf_pkg::REQ_STOP, 8'h00, 1'b0));
    endtask

    // The mode is sampled at address match, so a change mid-transaction waits for the next.
    task automatic test_mode_change_mid_transaction();
        send_item(make_item(i2c_trf_pkg::REQ_ADDR, 8'h00, 1'b0));
        write_select_mode(1'b0);
        send_item(make_item(i2c_trf_pkg::REQ_WRITE, 8'h03, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_STOP, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_ADDR, 8'h00, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_WRITE, 8'h03, 1'b0));
        send_item(make_item(i2c_trf_pkg::REQ_STOP, 8'h00, 1'b0));
    endtask

    // Mostly well-formed transactions with random content, some noise and broken ones.
    task automatic test_random_traffic(input int n_items);
        int target;
        int len;
        int dir;
        logic [7:0] pbyte;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                send_item(make_item(i2c_trf_pkg::REQ_ADDR, 8'($urandom),
                                    $urandom_range(0, 5) == 0));
                if (mode_model)
                begin
                    pbyte = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, NREG - 1));
                    send_item(make_item(i2c_trf_pkg::REQ_WRITE, pbyte,
                                        $urandom_range(0, 5) == 0));
                end
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2 * NREG + 2)
                                                  : $urandom_range(1, 4);
                dir = $urandom_range(0, 2);
                repeat (len)
                begin
                    if (dir == 0 || (dir == 2 && $urandom_range(0, 1) == 0))
                    begin
                        send_item(make_item(i2c_trf_pkg::REQ_WRITE, 8'($urandom),
                                            $urandom_range(0, 5) == 0));
                    end
                    else
                    begin
                        send_item(make_item(i2c_trf_pkg::REQ_READ, 8'($urandom),
                                            $urandom_range(0, 5) == 0));
                    end
                end
                // Now and then the stop is left out, so the next match restarts mid-transaction.
                if ($urandom_range(0, 9) != 0)
                begin
                    send_item(make_item(i2c_trf_pkg::REQ_STOP, 8'($urandom),
                                        $urandom_range(0, 5) == 0));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    send_item(make_item(i2c_trf_pkg::req_e_t'($urandom_range(0, 3)),
                                        8'($urandom), 1'($urandom_range(0, 1))));
                end
            end
            if ($urandom_range(0, 7) == 0)
            begin
                write_select_mode(1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        for (int i = 0; i < NREG; i++)
        begin
            bank_model[i] = 8'h00;
        end
        ptr_model = 8'd0;
        arm_ptr_model = 1'b0;
        busy_model = 1'b0;
        changed_model = 1'b0;
        mode_model = 1'b0;
        errors = 0;
        items_sent = 0;
        results_checked = 0;
        addr_count = 0;
        data_write_count = 0;
        ptr_write_count = 0;
        read_count = 0;
        stop_count = 0;
        mode_writes = 0;
        idle_enable = 1'b1;

        rst_n <= 1'b0;
        start <= 1'b0;
        req <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_plain_transfers();
        test_pointer_select();
        test_mode_change_mid_transaction();
        test_random_traffic(RANDOM_ITEMS - CALM_ITEMS);
        write_select_mode(1'b1);
        idle_enable = 1'b0;
        test_random_traffic(CALM_ITEMS / 2);
        write_select_mode(1'b0);
        test_random_traffic(CALM_ITEMS / 2);

        start <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Covered %0d items: %0d address matches, %0d data writes, %0d pointer bytes,",
                 items_sent, addr_count, data_write_count, ptr_write_count);
        $display("%0d reads, %0d stops, %0d mode writes; %0d results compared, %0d mismatches.",
                 read_count, stop_count, mode_writes, results_checked, errors);
        if (errors == 0 && expected_results.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/i2c_trf_pkg.sv
rtl/i2c_trf_ctrl.sv
rtl/i2c_trf_datapath.sv
rtl/i2c_target_register_file.sv
tb/i2c_target_register_file_tb.sv
